FILE: rtl/http_get_request_validator_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the request validator core
// each macro expands to one labeled concurrent assertion on the clock
// ----------------------------------------------------------------------------
`ifndef HTTP_GET_REQUEST_VALIDATOR_CORE_ASSERT_SVH
`define HTTP_GET_REQUEST_VALIDATOR_CORE_ASSERT_SVH

// assertion that is switched off while reset is high
`define HGRV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// assertion that also holds across reset
`define HGRV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: rtl/hgrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgrv_pkg
// shared types, constants and literal tables for the request validator
// ----------------------------------------------------------------------------
package hgrv_pkg;

   // sizes
   localparam int MAX_PATH    = 1024;
   localparam int URL_CNT_W   = $clog2(MAX_PATH + 1);
   localparam int PATH_LEN_W  = 10;
   localparam int LEN_SAT     = (1 << PATH_LEN_W) - 1;
   localparam int POS_W       = 4;
   localparam int POS_SAT     = (1 << POS_W) - 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field lengths
   localparam int METHOD_LEN  = 3;
   localparam int VERSION_LEN = 9;
   localparam int VER_DIGIT   = 7;
   localparam int HOST_PREFIX = 6;
   localparam int HOST_MIN    = 7;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;

   // parser phase
   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_URL     = 3'd1,
      PH_VERSION = 3'd2,
      PH_HOST    = 3'd3,
      PH_REST    = 3'd4
   } phase_type;

   // one queue entry: the results caused by one request byte
   typedef struct packed {
      logic                  path_valid;
      logic                  verdict_valid;
      logic [7:0]            path_byte;
      logic [PATH_LEN_W-1:0] path_length;
      logic                  request_ok;
   } entry_type;

   // method literal
   function automatic logic [7:0] get_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h47;
         4'd1:    c = 8'h45;
         4'd2:    c = 8'h54;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // version literal, digit position checked apart
   function automatic logic [7:0] ver_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h48;
         4'd1:    c = 8'h54;
         4'd2:    c = 8'h54;
         4'd3:    c = 8'h50;
         4'd4:    c = 8'h2f;
         4'd5:    c = 8'h31;
         4'd6:    c = 8'h2e;
         4'd7:    c = 8'h30;
         4'd8:    c = CH_CR;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // host header prefix
   function automatic logic [7:0] host_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h48;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h73;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h3a;
         4'd5:    c = CH_SPACE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/hgrv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgrv_front
// accepts request bytes, tracks the field phase and match flags, and
// pushes the path and verdict results of each byte into the queue
// ----------------------------------------------------------------------------
module hgrv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   input  logic                q_full,
   output logic                q_push,
   output hgrv_pkg::entry_type q_data
);

   hgrv_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [hgrv_pkg::POS_W-1:0]     pos_ff, pos_in, pos_upd;
   logic                           method_ff, method_in, method_upd;
   logic                           url_ok_ff, url_ok_in, url_ok_upd;
   logic                           ver_ff, ver_in, ver_upd;
   logic                           host_ff, host_in, host_upd;
   logic                           prev_cr_ff, prev_cr_in;
   logic [hgrv_pkg::URL_CNT_W-1:0] url_cnt_ff, url_cnt_in, url_cnt_upd;

   logic accept;
   logic is_space, is_lf, is_cr;
   logic [hgrv_pkg::POS_W-1:0] pos_bump;
   logic [hgrv_pkg::URL_CNT_W+hgrv_pkg::PATH_LEN_W-1:0] url_wide;
   logic [hgrv_pkg::PATH_LEN_W-1:0] shown_len;
   logic host_ok, verdict_ok, path_hit;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign is_space  = (req_byte == hgrv_pkg::CH_SPACE);
   assign is_lf     = (req_byte == hgrv_pkg::CH_LF);
   assign is_cr     = (req_byte == hgrv_pkg::CH_CR);
   assign pos_bump  = (pos_ff == hgrv_pkg::POS_W'(hgrv_pkg::POS_SAT)) ? pos_ff
                                                                       : pos_ff + 1'b1;

   // phase next state: field delimiters, then back to method on the last byte
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         hgrv_pkg::PH_METHOD:  if (is_space) phase_step = hgrv_pkg::PH_URL;
         hgrv_pkg::PH_URL:     if (is_space) phase_step = hgrv_pkg::PH_VERSION;
         hgrv_pkg::PH_VERSION: if (is_lf) phase_step = hgrv_pkg::PH_HOST;
         hgrv_pkg::PH_HOST:    if (is_lf) phase_step = hgrv_pkg::PH_REST;
         hgrv_pkg::PH_REST:    phase_step = hgrv_pkg::PH_REST;
         default:              phase_step = hgrv_pkg::PH_METHOD;
      endcase
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_last ? hgrv_pkg::PH_METHOD : phase_step;
      end
   end

   // field position and match flag updates for the current byte
   always_comb begin
      pos_upd     = pos_ff;
      method_upd  = method_ff;
      url_ok_upd  = url_ok_ff;
      ver_upd     = ver_ff;
      host_upd    = host_ff;
      url_cnt_upd = url_cnt_ff;
      path_hit    = 1'b0;
      unique case (phase_ff)
         hgrv_pkg::PH_METHOD: begin
            if (is_space) begin
               if (pos_ff != hgrv_pkg::POS_W'(hgrv_pkg::METHOD_LEN)) method_upd = 1'b0;
               pos_upd = '0;
            end else begin
               if (pos_ff >= hgrv_pkg::POS_W'(hgrv_pkg::METHOD_LEN) ||
                   req_byte != hgrv_pkg::get_char(pos_ff)) method_upd = 1'b0;
               pos_upd = pos_bump;
            end
         end
         hgrv_pkg::PH_URL: begin
            if (is_space) begin
               pos_upd = '0;
            end else begin
               path_hit = 1'b1;
               if (url_cnt_ff == '0 && req_byte == hgrv_pkg::CH_SLASH) url_ok_upd = 1'b1;
               if (url_cnt_ff < hgrv_pkg::URL_CNT_W'(hgrv_pkg::MAX_PATH)) begin
                  url_cnt_upd = url_cnt_ff + 1'b1;
               end
            end
         end
         hgrv_pkg::PH_VERSION: begin
            if (is_lf) begin
               if (pos_ff != hgrv_pkg::POS_W'(hgrv_pkg::VERSION_LEN)) ver_upd = 1'b0;
               pos_upd = '0;
            end else begin
               if (pos_ff >= hgrv_pkg::POS_W'(hgrv_pkg::VERSION_LEN)) begin
                  ver_upd = 1'b0;
               end else if (pos_ff == hgrv_pkg::POS_W'(hgrv_pkg::VER_DIGIT)) begin
                  if (req_byte != hgrv_pkg::CH_ZERO && req_byte != hgrv_pkg::CH_ONE) begin
                     ver_upd = 1'b0;
                  end
               end else if (req_byte != hgrv_pkg::ver_char(pos_ff)) begin
                  ver_upd = 1'b0;
               end
               pos_upd = pos_bump;
            end
         end
         hgrv_pkg::PH_HOST: begin
            if (is_lf) begin
               if (pos_ff < hgrv_pkg::POS_W'(hgrv_pkg::HOST_MIN) || !prev_cr_ff) begin
                  host_upd = 1'b0;
               end
               pos_upd = '0;
            end else begin
               if (pos_ff < hgrv_pkg::POS_W'(hgrv_pkg::HOST_PREFIX) &&
                   req_byte != hgrv_pkg::host_char(pos_ff)) host_upd = 1'b0;
               pos_upd = pos_bump;
            end
         end
         default: begin
         end
      endcase
   end

   // verdict and saturated length from the updated state
   always_comb begin
      url_wide  = {{hgrv_pkg::PATH_LEN_W{1'b0}}, url_cnt_upd};
      shown_len = (url_wide > ($bits(url_wide))'(hgrv_pkg::LEN_SAT))
                  ? hgrv_pkg::PATH_LEN_W'(hgrv_pkg::LEN_SAT)
                  : url_wide[hgrv_pkg::PATH_LEN_W-1:0];
      case (phase_step)
         hgrv_pkg::PH_HOST:
            host_ok = host_upd && (pos_upd >= hgrv_pkg::POS_W'(hgrv_pkg::HOST_MIN)) && is_cr;
         hgrv_pkg::PH_REST: host_ok = host_upd;
         default:           host_ok = 1'b0;
      endcase
      verdict_ok = method_upd && url_ok_upd && ver_upd && host_ok &&
                   (url_cnt_upd < hgrv_pkg::URL_CNT_W'(hgrv_pkg::MAX_PATH));
   end

   // queue push
   always_comb begin
      q_push               = accept && (path_hit || req_last);
      q_data.path_valid    = path_hit;
      q_data.verdict_valid = req_last;
      q_data.path_byte     = req_byte;
      q_data.path_length   = shown_len;
      q_data.request_ok    = verdict_ok;
   end

   // state next values, cleared after the verdict
   always_comb begin
      pos_in     = pos_ff;
      method_in  = method_ff;
      url_ok_in  = url_ok_ff;
      ver_in     = ver_ff;
      host_in    = host_ff;
      prev_cr_in = prev_cr_ff;
      url_cnt_in = url_cnt_ff;
      if (accept) begin
         if (req_last) begin
            pos_in     = '0;
            method_in  = 1'b1;
            url_ok_in  = 1'b0;
            ver_in     = 1'b1;
            host_in    = 1'b1;
            prev_cr_in = 1'b0;
            url_cnt_in = '0;
         end else begin
            pos_in     = pos_upd;
            method_in  = method_upd;
            url_ok_in  = url_ok_upd;
            ver_in     = ver_upd;
            host_in    = host_upd;
            prev_cr_in = is_cr;
            url_cnt_in = url_cnt_upd;
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hgrv_pkg::PH_METHOD;
         pos_ff     <= '0;
         method_ff  <= 1'b1;
         url_ok_ff  <= 1'b0;
         ver_ff     <= 1'b1;
         host_ff    <= 1'b1;
         prev_cr_ff <= 1'b0;
         url_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         method_ff  <= method_in;
         url_ok_ff  <= url_ok_in;
         ver_ff     <= ver_in;
         host_ff    <= host_in;
         prev_cr_ff <= prev_cr_in;
         url_cnt_ff <= url_cnt_in;
      end
   end

endmodule

FILE: rtl/hgrv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgrv_queue
// short first-in first-out queue of result entries between front and back
// ----------------------------------------------------------------------------
module hgrv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hgrv_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output hgrv_pkg::entry_type pop_data,
   output logic                not_empty
);

   hgrv_pkg::entry_type slot_ff [hgrv_pkg::QUEUE_DEPTH];
   logic [hgrv_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hgrv_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hgrv_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == hgrv_pkg::QCNT_W'(hgrv_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/hgrv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgrv_back
// drains queue entries into the result register, a path result first and
// then a verdict when one entry carries both
// ----------------------------------------------------------------------------
module hgrv_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   input  hgrv_pkg::entry_type               q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_out_kind,
   output logic [7:0]                        rsp_path_byte,
   output logic [hgrv_pkg::PATH_LEN_W-1:0]   rsp_path_length,
   output logic                              rsp_request_ok,
   output logic                              rsp_run_end
);

   logic                            valid_ff, valid_in;
   logic                            kind_ff, kind_in;
   logic [7:0]                      byte_ff, byte_in;
   logic [hgrv_pkg::PATH_LEN_W-1:0] len_ff, len_in;
   logic                            ok_ff, ok_in;
   logic                            end_ff, end_in;
   logic                            pend_ff, pend_in;
   logic [hgrv_pkg::PATH_LEN_W-1:0] pend_len_ff, pend_len_in;
   logic                            pend_ok_ff, pend_ok_in;
   logic                            load;

   assign load = !valid_ff || !rsp_stall;

   // choose the next result: held verdict, then the queue head
   always_comb begin
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      len_in      = len_ff;
      ok_in       = ok_ff;
      end_in      = end_ff;
      pend_in     = pend_ff;
      pend_len_in = pend_len_ff;
      pend_ok_in  = pend_ok_ff;
      q_pop       = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            kind_in  = 1'b1;
            byte_in  = '0;
            len_in   = pend_len_ff;
            ok_in    = pend_ok_ff;
            end_in   = 1'b1;
            pend_in  = 1'b0;
         end else if (q_not_empty) begin
            q_pop       = 1'b1;
            valid_in    = 1'b1;
            len_in      = q_data.path_length;
            pend_len_in = q_data.path_length;
            pend_ok_in  = q_data.request_ok;
            if (q_data.path_valid) begin
               kind_in = 1'b0;
               byte_in = q_data.path_byte;
               ok_in   = 1'b0;
               end_in  = !q_data.verdict_valid;
               pend_in = q_data.verdict_valid;
            end else begin
               kind_in = 1'b1;
               byte_in = '0;
               ok_in   = q_data.request_ok;
               end_in  = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      len_ff      <= len_in;
      ok_ff       <= ok_in;
      end_ff      <= end_in;
      pend_len_ff <= pend_len_in;
      pend_ok_ff  <= pend_ok_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_kind    = kind_ff;
   assign rsp_path_byte   = byte_ff;
   assign rsp_path_length = len_ff;
   assign rsp_request_ok  = ok_ff;
   assign rsp_run_end     = end_ff;

endmodule

FILE: rtl/http_get_request_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_get_request_validator_core
// byte stream parser for a GET request line and host header, streaming the
// url bytes out and closing each request with a verdict
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_byte, req_last
//  rsp      out        rsp_valid/rsp_stall   rsp_out_kind, rsp_path_byte,
//                                            rsp_path_length, rsp_request_ok,
//                                            rsp_run_end
//
//  one request byte per cycle while req_stall is low; the parser state is registered
//  an accepted byte passes through the queue into the result register
//  a last byte inside the url gives two results, which leave the result
//  register one after the other; the four-entry queue absorbs the extra result
//  req_stall rises only when the queue is full
//  synchronous reset returns the parser to the method field and empties
//  the queue and result register
// ----------------------------------------------------------------------------
module http_get_request_validator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_byte,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_out_kind,
   output logic [7:0]                      rsp_path_byte,
   output logic [hgrv_pkg::PATH_LEN_W-1:0] rsp_path_length,
   output logic                            rsp_request_ok,
   output logic                            rsp_run_end
);

   logic                q_push, q_full, q_pop, q_not_empty;
   hgrv_pkg::entry_type q_push_data, q_pop_data;

   // parser front end
   hgrv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // result queue
   hgrv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   // result back end
   hgrv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_path_byte   (rsp_path_byte),
      .rsp_path_length (rsp_path_length),
      .rsp_request_ok  (rsp_request_ok),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

FILE: rtl/hgrv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgrv_checker
// port level checks on the result channel of the request validator
// ----------------------------------------------------------------------------
`include "http_get_request_validator_core_assert.svh"

module hgrv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_out_kind,
   input logic [7:0]                      rsp_path_byte,
   input logic [hgrv_pkg::PATH_LEN_W-1:0] rsp_path_length,
   input logic                            rsp_request_ok,
   input logic                            rsp_run_end
);

   logic [hgrv_pkg::PATH_LEN_W+10:0] rsp_payload;

   // result payload as one word
   assign rsp_payload = {rsp_out_kind, rsp_path_byte, rsp_path_length,
                         rsp_request_ok, rsp_run_end};

   // result register empties on reset
   `HGRV_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // a stalled transaction holds its payload
   `HGRV_ASSERT(a_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stall")

   // a verdict closes the run and carries no path byte
   `HGRV_ASSERT(a_verdict_form, rsp_valid && rsp_out_kind |-> rsp_run_end && rsp_path_byte == 8'h00, "malformed verdict")

   // a path result never carries an accepting verdict
   `HGRV_ASSERT(a_path_form, rsp_valid && !rsp_out_kind |-> !rsp_request_ok, "path result flagged ok")

   // an accepted request has a non-empty url
   `HGRV_ASSERT(a_ok_len, rsp_valid && rsp_out_kind && rsp_request_ok |-> rsp_path_length != '0, "ok verdict with empty url")

endmodule

bind http_get_request_validator_core hgrv_checker u_hgrv_checker (.*);

FILE: tb/tb_http_get_request_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_get_request_validator_core
// feeds request text byte by byte into the validator core and compares every
// streamed url byte and every verdict with a cycle-free parser model kept in
// the bench; a directed request table runs first, then random requests with
// random idling on both sides, a long result hold-off and a full drain
// ----------------------------------------------------------------------------
module tb_http_get_request_validator_core;

   // run sizing
   localparam int RANDOM_ITEMS   = 200;
   localparam int HOLD_AT        = 40;
   localparam int PAUSE_AT       = 100;
   localparam int QUIET_AT       = 160;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_LIMIT    = 50000;
   localparam int TAIL_CYCLES    = 16;
   localparam int DIR_ROWS       = 23;

   // result kinds
   localparam logic KIND_PATH    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // literals the parser matches against
   localparam string METHOD_TXT  = "GET";
   localparam string VERSION_TXT = "HTTP/1.0\015";
   localparam string HOST_TXT    = "Host: ";

   typedef logic [7:0] byte_q_type[$];

   // one result transaction
   typedef struct {
      logic                            kind;
      logic [7:0]                      pbyte;
      logic [hgrv_pkg::PATH_LEN_W-1:0] plen;
      logic                            ok;
      logic                            run_end;
   } result_type;

   // one directed request: head, a run of pad bytes, tail
   typedef struct {
      string      head;
      int         pad_n;
      logic [7:0] pad_b;
      string      tail;
      bit         typed;
      bit         ok_want;
   } dir_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [7:0]                      req_byte;
   logic                            req_last;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_out_kind;
   logic [7:0]                      rsp_path_byte;
   logic [hgrv_pkg::PATH_LEN_W-1:0] rsp_path_length;
   logic                            rsp_request_ok;
   logic                            rsp_run_end;

   // parser model state
   hgrv_pkg::phase_type prs_phase;
   int                  prs_pos;
   bit                  get_good;
   bit                  url_good;
   bit                  ver_good;
   bit                  host_good;
   logic [7:0]          prev_byte;
   int                  url_len;

   result_type  pending_results[$];
   int          err_count;
   int          sent_count;
   bit          tx_idle_on;
   bit          rx_idle_on;
   bit          long_hold_req;
   int          hold_left;

   dir_row_type dir_rows [DIR_ROWS];

   http_get_request_validator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte        (req_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_path_byte   (rsp_path_byte),
      .rsp_path_length (rsp_path_length),
      .rsp_request_ok  (rsp_request_ok),
      .rsp_run_end     (rsp_run_end)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   // parser model back to its idle state
   function automatic void clear_parser();
      prs_phase = hgrv_pkg::PH_METHOD;
      prs_pos   = 0;
      get_good  = 1'b1;
      url_good  = 1'b0;
      ver_good  = 1'b1;
      host_good = 1'b1;
      prev_byte = 8'h00;
      url_len   = 0;
   endfunction

   function automatic logic [hgrv_pkg::PATH_LEN_W-1:0] shown_len();
      return (url_len > hgrv_pkg::LEN_SAT) ? hgrv_pkg::PATH_LEN_W'(hgrv_pkg::LEN_SAT)
                                           : hgrv_pkg::PATH_LEN_W'(url_len);
   endfunction

   // advance the parser model by one accepted byte, queue what it produces
   function automatic void parse_byte(input logic [7:0] b, input logic l);
      result_type r;
      bit         host_end_ok;
      case (prs_phase)
         hgrv_pkg::PH_METHOD: begin
            if (b == hgrv_pkg::CH_SPACE) begin
               if (prs_pos != hgrv_pkg::METHOD_LEN) get_good = 1'b0;
               prs_phase = hgrv_pkg::PH_URL;
               prs_pos   = 0;
            end else begin
               if (prs_pos >= hgrv_pkg::METHOD_LEN || b != METHOD_TXT[prs_pos])
                  get_good = 1'b0;
               prs_pos++;
            end
         end
         hgrv_pkg::PH_URL: begin
            if (b == hgrv_pkg::CH_SPACE) begin
               prs_phase = hgrv_pkg::PH_VERSION;
               prs_pos   = 0;
            end else begin
               if (url_len == 0 && b == hgrv_pkg::CH_SLASH) url_good = 1'b1;
               if (url_len < hgrv_pkg::MAX_PATH) url_len++;
               r.kind    = KIND_PATH;
               r.pbyte   = b;
               r.plen    = shown_len();
               r.ok      = 1'b0;
               r.run_end = !l;
               pending_results.push_back(r);
            end
         end
         hgrv_pkg::PH_VERSION: begin
            if (b == hgrv_pkg::CH_LF) begin
               if (prs_pos != hgrv_pkg::VERSION_LEN) ver_good = 1'b0;
               prs_phase = hgrv_pkg::PH_HOST;
               prs_pos   = 0;
            end else begin
               if (prs_pos >= hgrv_pkg::VERSION_LEN) ver_good = 1'b0;
               else if (prs_pos == hgrv_pkg::VER_DIGIT) begin
                  if (b != hgrv_pkg::CH_ZERO && b != hgrv_pkg::CH_ONE) ver_good = 1'b0;
               end else if (b != VERSION_TXT[prs_pos]) ver_good = 1'b0;
               prs_pos++;
            end
         end
         hgrv_pkg::PH_HOST: begin
            if (b == hgrv_pkg::CH_LF) begin
               if (prs_pos < hgrv_pkg::HOST_MIN || prev_byte != hgrv_pkg::CH_CR)
                  host_good = 1'b0;
               prs_phase = hgrv_pkg::PH_REST;
               prs_pos   = 0;
            end else begin
               if (prs_pos < hgrv_pkg::HOST_PREFIX && b != HOST_TXT[prs_pos])
                  host_good = 1'b0;
               prs_pos++;
            end
         end
         default: begin
         end
      endcase
      prev_byte = b;

      // verdict closes the request
      if (l) begin
         if (prs_phase == hgrv_pkg::PH_HOST)
            host_end_ok = host_good && prs_pos >= hgrv_pkg::HOST_MIN &&
                          prev_byte == hgrv_pkg::CH_CR;
         else if (prs_phase == hgrv_pkg::PH_REST)
            host_end_ok = host_good;
         else
            host_end_ok = 1'b0;
         r.kind    = KIND_VERDICT;
         r.pbyte   = 8'h00;
         r.plen    = shown_len();
         r.ok      = get_good && url_good && url_len < hgrv_pkg::MAX_PATH && ver_good &&
                     host_end_ok;
         r.run_end = 1'b1;
         pending_results.push_back(r);
         clear_parser();
      end
   endfunction

   function automatic logic [7:0] any_but(input logic [7:0] avoid);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == avoid) c = c ^ 8'h01;
      return c;
   endfunction

   function automatic void push_text(ref byte_q_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   // corrupt a field: replace, drop or insert one byte
   function automatic void mutate(ref byte_q_type f);
      int k;
      k = (f.size() == 0) ? 0 : $urandom_range(0, f.size() - 1);
      case ($urandom_range(0, 2))
         0: if (f.size() != 0) f[k] = any_but(f[k]);
         1: if (f.size() != 0) f.delete(k);
         default: f.insert(k, 8'($urandom_range(0, 255)));
      endcase
   endfunction

   // random request: mostly well formed, some corrupted, some pure noise
   function automatic void build_request(ref byte_q_type q);
      byte_q_type f;
      int         n;
      q = {};
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(1, 30);
         repeat (n) q.push_back(8'($urandom_range(0, 255)));
         return;
      end

      // method
      f = {};
      push_text(f, METHOD_TXT);
      if ($urandom_range(0, 7) == 0) mutate(f);
      q = {q, f};
      q.push_back(hgrv_pkg::CH_SPACE);

      // url
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
         if (i == 0 && $urandom_range(0, 9) != 0) q.push_back(hgrv_pkg::CH_SLASH);
         else q.push_back(any_but(hgrv_pkg::CH_SPACE));
      end
      q.push_back(hgrv_pkg::CH_SPACE);

      // version line
      f = {};
      push_text(f, VERSION_TXT);
      f[hgrv_pkg::VER_DIGIT] = $urandom_range(0, 1) ? hgrv_pkg::CH_ONE : hgrv_pkg::CH_ZERO;
      if ($urandom_range(0, 7) == 0) mutate(f);
      q = {q, f};
      q.push_back(hgrv_pkg::CH_LF);

      // host line
      f = {};
      push_text(f, HOST_TXT);
      n = $urandom_range(0, 8);
      repeat (n) f.push_back(any_but(hgrv_pkg::CH_LF));
      f.push_back(hgrv_pkg::CH_CR);
      if ($urandom_range(0, 7) == 0) mutate(f);
      q = {q, f};
      q.push_back(hgrv_pkg::CH_LF);

      // trailing header bytes
      n = $urandom_range(0, 4);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));

      // early end
      if ($urandom_range(0, 9) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
   endfunction

   // offer one byte, return at the edge that accepts it
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b, l);
      sent_count++;
   endtask

   task automatic send_request(input byte_q_type q, input bit typed, input bit ok_want);
      for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
      // typed verdict overrides the model's
      if (typed) pending_results[pending_results.size() - 1].ok = ok_want;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         err_count++;
      end
   endtask

   // receiver: random stall bursts and one long hold-off
   initial begin
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) hold_left--;
         else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0)
            hold_left = $urandom_range(1, 10);
         rsp_stall <= (hold_left > 0);
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d byte %0h len %0d ok %0d end %0d",
                   rsp_out_kind, rsp_path_byte, rsp_path_length, rsp_request_ok,
                   rsp_run_end);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind);
               err_count++;
            end
            if (rsp_path_byte !== want.pbyte) begin
               $error("path_byte: expected %0h, got %0h", want.pbyte, rsp_path_byte);
               err_count++;
            end
            if (rsp_path_length !== want.plen) begin
               $error("path_length: expected %0d, got %0d", want.plen, rsp_path_length);
               err_count++;
            end
            if (rsp_request_ok !== want.ok) begin
               $error("request_ok: expected %0d, got %0d", want.ok, rsp_request_ok);
               err_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_run_end);
               err_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      byte_q_type q;
      int         rnd_base;
      int         done_items;
      bit         held;
      bit         paused;

      err_count     = 0;
      sent_count    = 0;
      tx_idle_on    = 1'b0;
      rx_idle_on    = 1'b0;
      long_hold_req = 1'b0;
      held          = 1'b0;
      paused        = 1'b0;
      clear_parser();

      // directed requests
      dir_rows[0]  = '{"GET / HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 1};
      dir_rows[1]  = '{"GET /", 3, 8'hff, " HTTP/1.0\015\nHost: ab\015\n", 1, 1};
      dir_rows[2]  = '{"GET /", 2, 8'h00, " HTTP/1.1\015\nHost: \015\n", 1, 1};
      dir_rows[3]  = '{"POST / HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[4]  = '{"GE / HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[5]  = '{"GETT / HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[6]  = '{" / HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[7]  = '{"GET x HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[8]  = '{"GET  HTTP/1.1\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[9]  = '{"GET / HTTP/1.2\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[10] = '{"GET / HTTP/1.1\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[11] = '{"GET / HTTP/1.10\015\nHost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[12] = '{"GET / HTTP/1.1\015\nhost: a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[13] = '{"GET / HTTP/1.1\015\nHost: a\n", 0, 8'h00, "", 1, 0};
      dir_rows[14] = '{"GET / HTTP/1.1\015\nHost:a\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[15] = '{"GET", 0, 8'h00, "", 1, 0};
      dir_rows[16] = '{"GET /ab", 0, 8'h00, "", 1, 0};
      dir_rows[17] = '{"GET / ", 0, 8'h00, "", 1, 0};
      dir_rows[18] = '{"GET / HTTP/1.1\015\n", 0, 8'h00, "", 1, 0};
      dir_rows[19] = '{"GET /q HTTP/1.1\015\nHost: a\015", 0, 8'h00, "", 0, 0};
      dir_rows[20] = '{"GET /q HTTP/1.0\015\nHost: a\015\nX: y", 0, 8'h00, "", 0, 0};
      dir_rows[21] = '{"GET /", hgrv_pkg::MAX_PATH, 8'h62, " HTTP/1.1\015\nHost: a\015\n",
                       1, 0};
      dir_rows[22] = '{"", 1, 8'hff, "", 1, 0};

      // reset
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_byte  <= 8'h00;
      req_last  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         q = {};
         push_text(q, dir_rows[r].head);
         repeat (dir_rows[r].pad_n) q.push_back(dir_rows[r].pad_b);
         push_text(q, dir_rows[r].tail);
         tx_idle_on = (r % 3) != 0;
         rx_idle_on = (r % 4) != 1;
         send_request(q, dir_rows[r].typed, dir_rows[r].ok_want);
      end
      drain_results();

      // random requests
      rnd_base = sent_count;
      while (sent_count - rnd_base < RANDOM_ITEMS) begin
         done_items = sent_count - rnd_base;
         // long hold-off while bytes keep coming
         if (!held && done_items >= HOLD_AT) begin
            held          = 1'b1;
            long_hold_req = 1'b1;
         end
         // sender waits for a fully drained block
         if (!paused && done_items >= PAUSE_AT) begin
            paused = 1'b1;
            drain_results();
         end
         if (done_items >= QUIET_AT) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end else begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
         end
         build_request(q);
         send_request(q, 1'b0, 1'b0);
      end

      // end of run
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hgrv_pkg.sv
rtl/hgrv_front.sv
rtl/hgrv_queue.sv
rtl/hgrv_back.sv
rtl/http_get_request_validator_core.sv
rtl/hgrv_checker.sv
tb/tb_http_get_request_validator_core.sv
